[rtl/rhh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_pkg
// Shared constants for the robin hood hash table: defaults, codes, mixer.
// ----------------------------------------------------------------------------
package rhh_pkg;

	localparam int SLOTS_DEF      = 1024;
	localparam int VALUE_BITS_DEF = 32;

	localparam int KEY_BITS  = 64;
	localparam int VIN_BITS  = 32;
	localparam int FUNC_BITS = 2;
	localparam int STAT_BITS = 3;
	localparam int FILL_BITS = 10;

	localparam logic [FILL_BITS-1:0] MAX_FILL_RST = 10'd768;

	localparam logic [FUNC_BITS-1:0] FUNC_SET    = 2'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_GET    = 2'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 2'd2;
	localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 2'd3;

	localparam logic [STAT_BITS-1:0] ST_INSERTED = 3'd0;
	localparam logic [STAT_BITS-1:0] ST_UPDATED  = 3'd1;
	localparam logic [STAT_BITS-1:0] ST_FOUND    = 3'd2;
	localparam logic [STAT_BITS-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STAT_BITS-1:0] ST_REMOVED  = 3'd4;
	localparam logic [STAT_BITS-1:0] ST_FULL     = 3'd5;
	localparam logic [STAT_BITS-1:0] ST_CLEARED  = 3'd6;

	localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

endpackage

[rtl/rhh_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rhh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/rhh_hash.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_hash
// Home slot of a key: 64-bit mixer with one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module rhh_hash #(
	parameter int SLOTS = rhh_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rhh_pkg::KEY_BITS-1:0] key,
	output logic                       done,
	output logic [$clog2(SLOTS)-1:0]   home
);

	localparam int IDX = $clog2(SLOTS);

	localparam logic [2:0] H_IDLE = 3'd0;
	localparam logic [2:0] H_M0   = 3'd1;
	localparam logic [2:0] H_M1   = 3'd2;
	localparam logic [2:0] H_M2   = 3'd3;
	localparam logic [2:0] H_MIX  = 3'd4;

	logic [2:0]  state_q;
	logic        round_q;
	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [63:0] c;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;
	logic [63:0] fin;

	assign c    = round_q ? rhh_pkg::MIX_C2 : rhh_pkg::MIX_C1;
	// low 64 bits of x*c from three partial products
	assign op_a = (state_q == H_M1) ? x_q[63:32] : x_q[31:0];
	assign op_b = (state_q == H_M2) ? c[63:32] : c[31:0];
	assign prod = 64'(op_a) * 64'(op_b);
	assign fin  = acc_q ^ (acc_q >> 31);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			round_q <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				H_IDLE: begin
					if (start) begin
						round_q <= 1'b0;
						state_q <= H_M0;
					end
				end
				H_M0: state_q <= H_M1;
				H_M1: state_q <= H_M2;
				H_M2: state_q <= H_MIX;
				H_MIX: begin
					if (round_q) begin
						done    <= 1'b1;
						state_q <= H_IDLE;
					end else begin
						round_q <= 1'b1;
						state_q <= H_M0;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			H_IDLE: if (start) x_q <= key ^ (key >> 30);
			H_M0:   acc_q <= prod;
			H_M1:   acc_q <= acc_q + {prod[31:0], 32'd0};
			H_M2:   acc_q <= acc_q + {prod[31:0], 32'd0};
			H_MIX: begin
				x_q <= acc_q ^ (acc_q >> 27);
				if (round_q) home <= fin[IDX-1:0];
			end
			default: ;
		endcase
	end

endmodule

[rtl/robin_hood_hash_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// robin_hood_hash_table
// Fixed-capacity key/value table, robin hood probing, backward-shift remove.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   tuser func, tdata key,value
//  m_*      out  m_tvalid/m_tready   tuser status, tdata hit,value_out,entry_total
//  max_fill in   max_fill_we         max_fill_wdata
//
//  a request is hashed first (shared 32x32 multiplier), then probes slot by slot
//  on the single slot ram; an insert walks again from the home slot, slot by slot
//  up to the first empty one; a remove shifts the following slots back by one
//  place; a clear writes every slot empty.
//  the output register is then loaded in S_DONE and S_IDLE takes the next request.
//  after reset a clearing pass over every slot runs with s_tready low.
//  a finished result waits in the output register while m_tready is low.
// ----------------------------------------------------------------------------
module robin_hood_hash_table #(
	parameter int SLOTS      = rhh_pkg::SLOTS_DEF,
	parameter int VALUE_BITS = rhh_pkg::VALUE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [95:0]                    s_tdata,   // key, value
	input  logic [rhh_pkg::FUNC_BITS-1:0]  s_tuser,   // func
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [((33+$clog2(SLOTS+1)+7)/8)*8-1:0] m_tdata, // hit, value_out, entry_total
	output logic [rhh_pkg::STAT_BITS-1:0]  m_tuser,   // status
	input  logic                           max_fill_we,
	input  logic [rhh_pkg::FILL_BITS-1:0]  max_fill_wdata
);

	localparam int IDX  = $clog2(SLOTS);
	localparam int CNT  = $clog2(SLOTS + 1);
	localparam int OUTW = ((33 + CNT + 7) / 8) * 8;
	localparam int VB   = VALUE_BITS;

	typedef struct packed {
		logic                          used;
		logic [rhh_pkg::KEY_BITS-1:0]  key;
		logic [VB-1:0]                 val;
		logic [IDX-1:0]                pdist;
	} slot_t;

	localparam int SW = $bits(slot_t);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HASH = 3'd1;
	localparam logic [2:0] S_LOOK = 3'd2;
	localparam logic [2:0] S_INS  = 3'd3;
	localparam logic [2:0] S_DEL  = 3'd4;
	localparam logic [2:0] S_CLR  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]                     state_q;
	logic                           clr_op_q;
	logic [CNT-1:0]                 cnt_q;
	logic [rhh_pkg::FILL_BITS-1:0]  max_fill_q;
	logic [rhh_pkg::FUNC_BITS-1:0]  func_q;
	logic [rhh_pkg::KEY_BITS-1:0]   key_q;
	logic [VB-1:0]                  val_q;
	logic [IDX-1:0]                 home_q;
	logic [IDX-1:0]                 pos_q;
	logic [IDX-1:0]                 d_q;
	slot_t                          carry_q;
	logic [rhh_pkg::STAT_BITS-1:0]  res_status_q;
	logic                           res_hit_q;
	logic [31:0]                    res_val_q;
	logic                           m_tvalid_q;
	logic [rhh_pkg::STAT_BITS-1:0]  out_status_q;
	logic [OUTW-1:0]                out_data_q;

	logic           hash_start;
	logic           hash_done;
	logic [IDX-1:0] hash_home;

	logic           we;
	logic [IDX-1:0] waddr;
	slot_t          wslot;
	logic [IDX-1:0] raddr;
	logic [SW-1:0]  rdata;
	slot_t          rs;
	logic [IDX-1:0] pos_nx;
	logic [IDX-1:0] pos_nx2;
	logic           accept;
	logic           absent;
	logic           full;
	logic [63:0]    val_wide;
	logic [63:0]    rval_wide;

	function automatic logic [IDX-1:0] next_pos(input logic [IDX-1:0] p);
		next_pos = (p == IDX'(SLOTS - 1)) ? '0 : IDX'(p + 1'b1);
	endfunction

	assign rs        = slot_t'(rdata);
	assign pos_nx    = next_pos(pos_q);
	assign pos_nx2   = next_pos(pos_nx);
	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign absent    = !rs.used || (rs.pdist < d_q);
	assign full      = (cnt_q >= CNT'(max_fill_q)) || (CNT'(cnt_q + 1'b1) >= CNT'(SLOTS));
	assign val_wide  = {32'd0, s_tdata[95:64]};
	assign rval_wide = 64'(rs.val);

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = out_data_q;

	rhh_hash #(.SLOTS(SLOTS)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (s_tdata[63:0]),
		.done   (hash_done),
		.home   (hash_home)
	);

	rhh_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wslot),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign hash_start = accept && (s_tuser != rhh_pkg::FUNC_CLEAR);

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wslot = '0;
		raddr = pos_q;
		unique case (state_q)
			S_HASH: raddr = hash_home;
			S_LOOK: begin
				raddr = pos_nx;
				if (absent) begin
					raddr = home_q;
				end else if (rs.key == key_q && func_q == rhh_pkg::FUNC_SET) begin
					we        = 1'b1;
					wslot     = rs;
					wslot.val = val_q;
				end
			end
			S_INS: begin
				raddr = pos_nx;
				if (!rs.used || rs.pdist < carry_q.pdist) begin
					we    = 1'b1;
					wslot = carry_q;
				end
			end
			S_DEL: begin
				raddr = pos_nx2;
				we    = 1'b1;
				if (rs.used && rs.pdist != '0) begin
					wslot       = rs;
					wslot.pdist = IDX'(rs.pdist - 1'b1);
				end
			end
			S_CLR: we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_op_q   <= 1'b0;
			cnt_q      <= '0;
			max_fill_q <= rhh_pkg::MAX_FILL_RST;
			m_tvalid_q <= 1'b0;
			pos_q      <= '0;
		end else begin
			if (max_fill_we) max_fill_q <= max_fill_wdata;
			if (m_tvalid_q && m_tready && state_q != S_DONE) m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_tuser == rhh_pkg::FUNC_CLEAR) begin
							pos_q    <= '0;
							clr_op_q <= 1'b1;
							state_q  <= S_CLR;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					if (hash_done) begin
						pos_q   <= hash_home;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (absent) begin
						if (func_q == rhh_pkg::FUNC_SET && !full) begin
							pos_q   <= home_q;
							state_q <= S_INS;
						end else begin
							state_q <= S_DONE;
						end
					end else if (rs.key == key_q) begin
						state_q <= (func_q == rhh_pkg::FUNC_REMOVE) ? S_DEL : S_DONE;
					end else begin
						pos_q <= pos_nx;
					end
				end
				S_INS: begin
					if (!rs.used) begin
						cnt_q   <= CNT'(cnt_q + 1'b1);
						state_q <= S_DONE;
					end else begin
						pos_q <= pos_nx;
					end
				end
				S_DEL: begin
					if (!rs.used || rs.pdist == '0) begin
						cnt_q   <= CNT'(cnt_q - 1'b1);
						state_q <= S_DONE;
					end else begin
						pos_q <= pos_nx;
					end
				end
				S_CLR: begin
					pos_q <= pos_nx;
					if (pos_q == IDX'(SLOTS - 1)) begin
						cnt_q    <= '0;
						clr_op_q <= 1'b0;
						state_q  <= clr_op_q ? S_DONE : S_IDLE;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					func_q       <= s_tuser;
					key_q        <= s_tdata[63:0];
					val_q        <= val_wide[VB-1:0];
					res_status_q <= rhh_pkg::ST_CLEARED;
					res_hit_q    <= 1'b0;
					res_val_q    <= '0;
				end
			end
			S_HASH: begin
				home_q <= hash_home;
				d_q    <= '0;
			end
			S_LOOK: begin
				if (absent) begin
					res_hit_q    <= 1'b0;
					res_status_q <= (func_q != rhh_pkg::FUNC_SET) ? rhh_pkg::ST_NOTFOUND :
						(full ? rhh_pkg::ST_FULL : rhh_pkg::ST_INSERTED);
					carry_q <= '{used: 1'b1, key: key_q, val: val_q, pdist: '0};
				end else if (rs.key == key_q) begin
					res_hit_q <= 1'b1;
					unique case (func_q)
						rhh_pkg::FUNC_SET:    res_status_q <= rhh_pkg::ST_UPDATED;
						rhh_pkg::FUNC_GET: begin
							res_status_q <= rhh_pkg::ST_FOUND;
							res_val_q    <= rval_wide[31:0];
						end
						default:              res_status_q <= rhh_pkg::ST_REMOVED;
					endcase
				end else begin
					d_q <= IDX'(d_q + 1'b1);
				end
			end
			S_INS: begin
				// displace a resident that sits closer to its home
				if (rs.used && rs.pdist < carry_q.pdist) begin
					carry_q <= '{used: rs.used, key: rs.key, val: rs.val,
						pdist: IDX'(rs.pdist + 1'b1)};
				end else begin
					carry_q.pdist <= IDX'(carry_q.pdist + 1'b1);
				end
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_status_q <= res_status_q;
					out_data_q   <= OUTW'({cnt_q, res_val_q, res_hit_q});
				end
			end
			default: ;
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT'(SLOTS - 1))
		else $error("entry count beyond capacity");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !we)
		else $error("slot write while idle");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside completion");

	a_hash_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		hash_start |-> (state_q == S_IDLE))
		else $error("hash started while busy");

endmodule
